// ===== sv/lbp_pattern_label_mapper_top_defines.svh =====
// assertion macros shared by the mapper rtl
`ifndef LBP_PATTERN_LABEL_MAPPER_TOP_DEFINES_SVH
`define LBP_PATTERN_LABEL_MAPPER_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define LBPM_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// consequence in the cycle after the condition
`define LBPM_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/lbpm_pkg.sv =====
package lbpm_pkg;

	localparam int CODE_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int BITS_W   = 4;
	localparam int MAX_BITS = 8;
	localparam int DEPTH    = 1 << CODE_W;

	localparam logic [1:0] MODE_IDENTITY    = 2'd0;
	localparam logic [1:0] MODE_UNIFORM     = 2'd1;
	localparam logic [1:0] MODE_ROT         = 2'd2;
	localparam logic [1:0] MODE_ROT_UNIFORM = 2'd3;

	localparam logic [1:0] CFG_PATTERN_BITS = 2'd0;
	localparam logic [1:0] CFG_MAPPING_MODE = 2'd1;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [BITS_W-1:0]  bits_t;

	// one item as it enters the label store stage
	typedef struct packed {
		logic   first;
		logic   rot;
		logic   uni;
		logic   uniform;
		code_t  rm;
		code_t  label;
		count_t count;
	} lbpm_req_t;

	function automatic bits_t eff_bits(bits_t raw);
		bits_t p;
		p = raw;
		if (p == 4'd0) p = 4'd1;
		if (p > BITS_W'(MAX_BITS)) p = BITS_W'(MAX_BITS);
		if (p > BITS_W'(CODE_W)) p = BITS_W'(CODE_W);
		return p;
	endfunction

	function automatic code_t code_mask(bits_t p);
		return CODE_W'((COUNT_W'(1) << p) - COUNT_W'(1));
	endfunction

	// rotate left by k within p bits, k below p
	function automatic code_t rot_by(code_t v, bits_t p, logic [2:0] k);
		return ((v << k) | (v >> (p - {1'b0, k}))) & code_mask(p);
	endfunction

endpackage

// ===== sv/lbpm_class.sv =====
module lbpm_class import lbpm_pkg::*; (
	input  code_t      code,
	input  bits_t      p,
	input  logic [1:0] mode,
	output code_t      rm,
	output logic       uniform,
	output code_t      label,
	output count_t     count
);

	code_t      r;
	code_t      r1;
	code_t      pp;
	logic [3:0] pc;

	always_comb begin
		rm = code;
		for (int k = 1; k < CODE_W; k++) begin
			r = rot_by(code, p, 3'(k));
			if (BITS_W'(k) < p && r < rm) rm = r;
		end
		r1 = rot_by(code, p, 3'd1);
		uniform = $countones(code ^ r1) <= 2;
		pc = 4'($countones(code));
		pp = {4'b0, p} * {4'b0, p - 4'd1};
		unique case (mode)
			MODE_IDENTITY: begin
				label = code;
				count = COUNT_W'(1) << p;
			end
			MODE_UNIFORM: begin
				// uniform codes get their running number in the store stage
				label = pp + 8'd2;
				count = {1'b0, pp} + 9'd3;
			end
			MODE_ROT: begin
				label = '0;
				count = '0;
			end
			MODE_ROT_UNIFORM: begin
				label = uniform ? {4'b0, pc} : {4'b0, p} + 8'd1;
				count = {5'b0, p} + 9'd2;
			end
			default: begin
				label = '0;
				count = '0;
			end
		endcase
	end

endmodule

// ===== sv/lbpm_label_store.sv =====
module lbpm_label_store import lbpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ld,
	input  lbpm_req_t req,
	input  logic      out_stall,
	output logic      out_valid,
	output code_t     label,
	output count_t    label_count
);

	code_t            mem [DEPTH];
	code_t            rd_q;
	code_t            label_q;
	count_t           count_q;
	logic             use_mem_q;
	logic             valid_out_q;
	count_t           next_label_q;
	code_t            seen_q;
	logic [DEPTH-1:0] valid_q;

	count_t nl_base;
	count_t nl_next;
	code_t  seen_base;
	logic   vbit;
	logic   miss;
	logic   take_seen;

	always_comb begin
		nl_base   = req.first ? '0 : next_label_q;
		seen_base = req.first ? '0 : seen_q;
		vbit      = !req.first && valid_q[req.rm];
		miss      = req.rot && !vbit;
		nl_next   = (miss && nl_base != count_t'(DEPTH)) ? nl_base + 9'd1 : nl_base;
		take_seen = req.uni && req.uniform;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q  <= 1'b0;
			next_label_q <= '0;
			seen_q       <= '0;
			valid_q      <= '0;
		end else begin
			if (ld) begin
				valid_out_q  <= 1'b1;
				next_label_q <= nl_next;
				seen_q       <= take_seen ? seen_base + 8'd1 : seen_base;
				valid_q      <= (req.first ? '0 : valid_q) |
					(miss ? (DEPTH'(1) << req.rm) : '0);
			end else if (valid_out_q && !out_stall) begin
				valid_out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			label_q   <= req.rot ? nl_base[CODE_W-1:0] : (take_seen ? seen_base : req.label);
			count_q   <= req.rot ? nl_next : req.count;
			use_mem_q <= req.rot && vbit;
		end
	end

	// every load reads the entry of its class and a miss also writes it; the read value is used only on a hit
	always_ff @(posedge clk) begin
		if (ld && miss) mem[req.rm] <= nl_base[CODE_W-1:0];
		if (ld) rd_q <= mem[req.rm];
	end

	assign out_valid   = valid_out_q;
	assign label       = use_mem_q ? rd_q : label_q;
	assign label_count = count_q;

endmodule

// ===== sv/lbp_pattern_label_mapper_top.sv =====
// local binary pattern label mapper
// input channel: pattern and first, moved on in_valid with in_stall low.
// a set first starts a new table and clears the label counters and the
// rotation class valid bits before that code is mapped.
// output channel: label and label_count, moved on out_valid with out_stall low.
// config channel: cfg_index selects pattern_bits (0) or mapping_mode (1),
// written on cfg_valid and cfg_ready; cfg_ready is always high. write only
// while no item is in flight.
// throughput: one code per cycle while out_stall is low; the store stage reads
// the label memory for every code and also writes it on a miss.
// a code is registered in code_s1, then in req_s2, then in the store stage outputs.
// when out_stall holds, results stay put; the pipeline keeps filling its free
// stages and raises in_stall only once all three stages hold an item.
// reset: pattern_bits is 8, mapping_mode is 3, counters and valid bits clear,
// the pipeline empties. label memory contents need no clearing.
`include "lbp_pattern_label_mapper_top_defines.svh"

module lbp_pattern_label_mapper_top import lbpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pattern,
	input  logic       first,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] label,
	output logic [8:0] label_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	bits_t      pattern_bits_q;
	logic [1:0] mapping_mode_q;
	bits_t      p;

	logic      v_s1;
	code_t     code_s1;
	logic      first_s1;
	logic      v_s2;
	lbpm_req_t req_s2;

	logic   ld2;
	logic   ld3;
	logic   in_acc;
	code_t  rm;
	logic   uniform;
	code_t  st_label;
	count_t st_count;

	assign cfg_ready = 1'b1;
	assign p         = eff_bits(pattern_bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bits_q <= 4'd8;
			mapping_mode_q <= MODE_ROT_UNIFORM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PATTERN_BITS: pattern_bits_q <= cfg_data;
				CFG_MAPPING_MODE: mapping_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ld3      = v_s2 && (!out_valid || !out_stall);
	assign ld2      = v_s1 && (!v_s2 || ld3);
	assign in_stall = v_s1 && v_s2 && !ld3;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_acc) v_s1 <= 1'b1;
			else if (ld2) v_s1 <= 1'b0;
			if (ld2) v_s2 <= 1'b1;
			else if (ld3) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_s1  <= pattern & code_mask(p);
			first_s1 <= first;
		end
	end

	lbpm_class u_class (
		.code    (code_s1),
		.p       (p),
		.mode    (mapping_mode_q),
		.rm      (rm),
		.uniform (uniform),
		.label   (st_label),
		.count   (st_count)
	);

	always_ff @(posedge clk) begin
		if (ld2) begin
			req_s2.first   <= first_s1;
			req_s2.rot     <= mapping_mode_q == MODE_ROT;
			req_s2.uni     <= mapping_mode_q == MODE_UNIFORM;
			req_s2.uniform <= uniform;
			req_s2.rm      <= rm;
			req_s2.label   <= st_label;
			req_s2.count   <= st_count;
		end
	end

	lbpm_label_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld3),
		.req         (req_s2),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.label       (label),
		.label_count (label_count)
	);

	`LBPM_ASSERT_SAME(a_stall_only_when_full, in_stall, v_s1 && v_s2 && out_valid && out_stall, "input stalled with a free stage")
	`LBPM_ASSERT_NEXT(a_first_rot_class, ld3 && req_s2.first && req_s2.rot, out_valid && label == 8'd0 && label_count == 9'd1, "first code of a rotation table not labelled zero")

endmodule
